>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the knee angle repetition counter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

>>> sv/karc_pkg.sv
// ----------------------------------------------------------------------------
// karc_pkg
// Types and constants shared by the knee angle repetition counter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package karc_pkg;

  localparam int ANGLE_W   = 11;
  localparam int RUN_W     = 8;
  localparam int DEPTH_W   = 11;
  localparam int OUT_CNT_W = 16;
  localparam int DIV_STEPS = 10;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [ANGLE_W-1:0] DOWN_THR_RESET = 11'd900;
  localparam logic [ANGLE_W-1:0] UP_THR_RESET   = 11'd1600;
  localparam logic [RUN_W-1:0]   CONFIRM_RESET  = 8'd3;
  localparam logic [ANGLE_W-1:0] ANGLE_RESET    = 11'd1800;
  localparam logic [DEPTH_W-1:0] DEPTH_FULL     = 11'd1024;

  // Register indexes (byte address bits [3:2]).
  localparam logic [1:0] REG_DOWN_THR = 2'd0;
  localparam logic [1:0] REG_UP_THR   = 2'd1;
  localparam logic [1:0] REG_CONFIRM  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic               start;
    logic [ANGLE_W-1:0] num;
    logic [ANGLE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_STEPS-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> sv/karc_div.sv
// ----------------------------------------------------------------------------
// karc_div
// Restoring serial divider giving the Q10 fraction num / den for num < den,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module karc_div (
  input  wire                clk,
  input  wire                rst,
  input  karc_pkg::div_req_t req,
  output karc_pkg::div_rsp_t rsp
);
  import karc_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [ANGLE_W-1:0]   rem;
  logic [ANGLE_W-1:0]   den;
  logic [DIV_STEPS-1:0] quot;
  logic [ANGLE_W:0]     shifted;
  logic                 fits;

  // The remainder always stays below the divisor, so it fits in ANGLE_W bits.
  assign shifted = {rem, 1'b0};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.num;
      den  <= req.den;
      quot <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= ANGLE_W'(shifted - {1'b0, den});
      end else begin
        rem <= shifted[ANGLE_W-1:0];
      end
      quot <= {quot[DIV_STEPS-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

`default_nettype wire

>>> sv/knee_angle_repetition_counter_unit.sv
// ----------------------------------------------------------------------------
// knee_angle_repetition_counter_unit
// Picks a knee angle per frame, arms on a confirmed standing posture, counts
// down-then-up repetitions with hysteresis and reports a Q10 depth fraction.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake                  Content
//  s_axis    in   tvalid/tready              two knee angles, two seen flags
//  m_axis    out  tvalid/tready              angle, count, phase, armed, depth
//  apb       in   psel/penable/pwrite/pready three config registers
//
// When the depth needs a division, an item passes the evaluate state, the
// 10-step serial divider and the hold state before the output register is
// loaded; otherwise it goes from evaluate straight to hold. The next item can
// be taken in the cycle after the load. The input is ready only in the idle state; a finished
// result waits in the output register, so the next item may be taken while it
// is stalled. Reset is synchronous; it restores state, settings, tracking and output valid, not data.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module knee_angle_repetition_counter_unit #(
  parameter int COUNT_BITS = 16
) (
  input  wire        clk,
  input  wire        rst,
  // tdata: [10:0] left_knee_angle, [21:11] right_knee_angle, [23:22] zero
  input  wire [23:0] s_axis_tdata,
  // tuser: [0] left_seen, [1] right_seen
  input  wire [1:0]  s_axis_tuser,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  // tdata: [10:0] selected_angle, [26:11] rep_count, [27] phase,
  //        [28] armed_flag, [39:29] depth_progress
  output logic [39:0] m_axis_tdata,
  // tuser: [0] frame_valid
  output logic [0:0] m_axis_tuser,
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire [3:0]  paddr,
  input  wire [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);
  import karc_pkg::*;

  localparam logic [COUNT_BITS-1:0] REP_MAX = {COUNT_BITS{1'b1}};

  function automatic logic [RUN_W-1:0] run_inc(input logic [RUN_W-1:0] r);
    run_inc = (r == {RUN_W{1'b1}}) ? r : r + 1'b1;
  endfunction

  // Configuration registers
  logic [ANGLE_W-1:0] down_thr;
  logic [ANGLE_W-1:0] up_thr;
  logic [RUN_W-1:0]   confirm;
  logic               cfg_write;
  logic [1:0]         reg_idx;

  // Tracking state
  logic [ANGLE_W-1:0]    current_angle;
  logic [COUNT_BITS-1:0] repetitions;
  logic                  down_phase;
  logic                  armed;
  logic                  last_valid;
  logic [RUN_W-1:0]      stand_run;
  logic [RUN_W-1:0]      down_run;
  logic [RUN_W-1:0]      up_run;

  logic [ANGLE_W-1:0]    current_angle_next;
  logic [COUNT_BITS-1:0] repetitions_next;
  logic                  down_phase_next;
  logic                  armed_next;
  logic                  last_valid_next;
  logic [RUN_W-1:0]      stand_run_next;
  logic [RUN_W-1:0]      down_run_next;
  logic [RUN_W-1:0]      up_run_next;

  logic [ANGLE_W-1:0] left_angle;
  logic [ANGLE_W-1:0] right_angle;
  logic               left_seen;
  logic               right_seen;
  logic [RUN_W-1:0]   need;

  state_t             state;
  state_t             state_next;
  logic               s_accept;
  logic               load_out;
  logic               div_start;
  logic               thr_ok;
  logic               need_div;
  logic [DEPTH_W-1:0] depth_special;
  logic [DEPTH_W-1:0] depth;
  logic [31:0]        rep_wide;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_thr <= DOWN_THR_RESET;
      up_thr   <= UP_THR_RESET;
      confirm  <= CONFIRM_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_DOWN_THR: down_thr <= pwdata[ANGLE_W-1:0];
        REG_UP_THR:   up_thr   <= pwdata[ANGLE_W-1:0];
        REG_CONFIRM:  confirm  <= pwdata[RUN_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DOWN_THR: prdata = 32'(down_thr);
      REG_UP_THR:   prdata = 32'(up_thr);
      REG_CONFIRM:  prdata = 32'(confirm);
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Frame update, applied at the edge that accepts the item
  // --------------------------------------------------------------------------
  assign left_angle  = s_axis_tdata[10:0];
  assign right_angle = s_axis_tdata[21:11];
  assign left_seen   = s_axis_tuser[0];
  assign right_seen  = s_axis_tuser[1];
  assign need        = (confirm == '0) ? RUN_W'(1) : confirm;
  assign s_accept    = s_axis_tvalid && s_axis_tready;

  always_comb begin
    current_angle_next = current_angle;
    repetitions_next   = repetitions;
    down_phase_next    = down_phase;
    armed_next         = armed;
    last_valid_next    = last_valid;
    stand_run_next     = stand_run;
    down_run_next      = down_run;
    up_run_next        = up_run;

    if (!left_seen && !right_seen) begin
      last_valid_next = 1'b0;
      stand_run_next  = '0;
      down_run_next   = '0;
      up_run_next     = '0;
    end else begin
      last_valid_next = 1'b1;
      if (left_seen && right_seen) begin
        current_angle_next = (left_angle < right_angle) ? left_angle : right_angle;
      end else begin
        current_angle_next = left_seen ? left_angle : right_angle;
      end

      if (!armed) begin
        if (current_angle_next > up_thr) begin
          stand_run_next = run_inc(stand_run);
          if (stand_run_next >= need) begin
            armed_next      = 1'b1;
            stand_run_next  = '0;
            down_phase_next = 1'b0;
          end
        end else begin
          stand_run_next = '0;
        end
      end else if (!down_phase) begin
        if (current_angle_next < down_thr) begin
          down_run_next = run_inc(down_run);
          if (down_run_next >= need) begin
            down_phase_next = 1'b1;
            down_run_next   = '0;
            up_run_next     = '0;
          end
        end else begin
          down_run_next = '0;
        end
      end else begin
        if (current_angle_next > up_thr) begin
          up_run_next = run_inc(up_run);
          if (up_run_next >= need) begin
            if (repetitions != REP_MAX) begin
              repetitions_next = repetitions + 1'b1;
            end
            down_phase_next = 1'b0;
            up_run_next     = '0;
            down_run_next   = '0;
          end
        end else begin
          up_run_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_angle <= ANGLE_RESET;
      repetitions   <= '0;
      down_phase    <= 1'b0;
      armed         <= 1'b0;
      last_valid    <= 1'b0;
      stand_run     <= '0;
      down_run      <= '0;
      up_run        <= '0;
    end else if (s_accept) begin
      current_angle <= current_angle_next;
      repetitions   <= repetitions_next;
      down_phase    <= down_phase_next;
      armed         <= armed_next;
      last_valid    <= last_valid_next;
      stand_run     <= stand_run_next;
      down_run      <= down_run_next;
      up_run        <= up_run_next;
    end
  end

  // --------------------------------------------------------------------------
  // Depth fraction: the clamped cases are settled at once, the rest divided
  // --------------------------------------------------------------------------
  assign thr_ok        = up_thr > down_thr;
  assign need_div      = last_valid && thr_ok && (current_angle < up_thr) &&
                         (current_angle > down_thr);
  assign depth_special = (last_valid && thr_ok && (current_angle <= down_thr)) ?
                         DEPTH_FULL : '0;

  assign div_req.start = div_start;
  assign div_req.num   = ANGLE_W'(up_thr - current_angle);
  assign div_req.den   = ANGLE_W'(up_thr - down_thr);

  karc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (state == ST_EVAL && !need_div) begin
      depth <= depth_special;
    end else if (state == ST_DIV && div_rsp.done) begin
      depth <= DEPTH_W'(div_rsp.quot);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_accept) state_next = ST_EVAL;
      ST_EVAL: state_next = need_div ? ST_DIV : ST_HOLD;
      ST_DIV:  if (div_rsp.done) state_next = ST_HOLD;
      ST_HOLD: if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_EVAL: div_start = need_div;
      ST_HOLD: load_out = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  assign rep_wide = 32'(repetitions);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= {depth, armed, down_phase, rep_wide[OUT_CNT_W-1:0], current_angle};
      m_axis_tuser <= last_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_PROP(a_rep_step, clk, rst, (repetitions == $past(repetitions)) || (repetitions == $past(repetitions) + 1'b1))
  `ASSERT_NEVER(a_armed_stays, clk, rst, $fell(armed))
  `ASSERT_PROP(a_depth_range, clk, rst, m_axis_tvalid |-> (m_axis_tdata[39:29] <= DEPTH_FULL))
  `ASSERT_PROP(a_div_done_in_div, clk, rst, div_rsp.done |-> (state == ST_DIV))

endmodule

`default_nettype wire

>>> tb/sv/knee_angle_repetition_counter_unit_test.sv
// ----------------------------------------------------------------------------
// knee_angle_repetition_counter_unit_test
// Streams pose frames into the repetition counter and checks every result
// against a cycle-free model of the arming, squat-phase and depth logic,
// across several threshold and confirmation settings with random back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module knee_angle_repetition_counter_unit_test;
  import karc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD    = 300;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic [ANGLE_W-1:0] left_angle;
    logic               left_seen;
    logic [ANGLE_W-1:0] right_angle;
    logic               right_seen;
  } frame_t;

  typedef struct {
    logic [ANGLE_W-1:0]   angle;
    logic [OUT_CNT_W-1:0] count;
    logic                 phase;
    logic                 armed;
    logic                 frame_ok;
    logic [DEPTH_W-1:0]   depth;
  } rep_status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  knee_angle_repetition_counter_unit #(
    .COUNT_BITS(16)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk = ~clk;

  frame_t      frame_q[$];
  rep_status_t status_q[$];
  int          errors = 0;
  int          results_seen = 0;
  int          cycles = 0;
  bit          idle_on = 1'b1;
  bit          in_taken = 1'b0;
  int          send_gap = 0;
  int          hold_left = 0;
  bit          long_hold_done = 1'b0;

  // Settings the stimulus is planned against.
  logic [ANGLE_W-1:0] plan_down;
  logic [ANGLE_W-1:0] plan_up;
  int                 plan_need;

  // Model state and register copies.
  logic [ANGLE_W-1:0]   thr_down = DOWN_THR_RESET;
  logic [ANGLE_W-1:0]   thr_up = UP_THR_RESET;
  logic [RUN_W-1:0]     confirm_cnt = CONFIRM_RESET;
  logic [ANGLE_W-1:0]   knee_angle = ANGLE_RESET;
  logic [OUT_CNT_W-1:0] rep_total = '0;
  logic                 squat_phase = 1'b0;
  logic                 armed_now = 1'b0;
  logic                 frame_seen = 1'b0;
  logic [RUN_W-1:0]     stand_frames = '0;
  logic [RUN_W-1:0]     low_frames = '0;
  logic [RUN_W-1:0]     high_frames = '0;

  function automatic logic [RUN_W-1:0] run_step(input logic [RUN_W-1:0] n);
    return (n == '1) ? n : n + 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic track_frame(input frame_t f, output rep_status_t r);
    logic [RUN_W-1:0] need;
    int num;
    int span;
    need = (confirm_cnt == '0) ? 8'd1 : confirm_cnt;
    if (!f.left_seen && !f.right_seen) begin
      frame_seen   = 1'b0;
      stand_frames = '0;
      low_frames   = '0;
      high_frames  = '0;
    end else begin
      frame_seen = 1'b1;
      if (f.left_seen && f.right_seen)
        knee_angle = (f.left_angle < f.right_angle) ? f.left_angle : f.right_angle;
      else
        knee_angle = f.left_seen ? f.left_angle : f.right_angle;
      if (!armed_now) begin
        if (knee_angle > thr_up) begin
          stand_frames = run_step(stand_frames);
          if (stand_frames >= need) begin
            armed_now    = 1'b1;
            stand_frames = '0;
            squat_phase  = 1'b0;
          end
        end else begin
          stand_frames = '0;
        end
      end else if (!squat_phase) begin
        if (knee_angle < thr_down) begin
          low_frames = run_step(low_frames);
          if (low_frames >= need) begin
            squat_phase = 1'b1;
            low_frames  = '0;
            high_frames = '0;
          end
        end else begin
          low_frames = '0;
        end
      end else begin
        if (knee_angle > thr_up) begin
          high_frames = run_step(high_frames);
          if (high_frames >= need) begin
            if (rep_total != '1) rep_total = rep_total + 1'b1;
            squat_phase = 1'b0;
            high_frames = '0;
            low_frames  = '0;
          end
        end else begin
          high_frames = '0;
        end
      end
    end
    r.angle    = knee_angle;
    r.count    = rep_total;
    r.phase    = squat_phase;
    r.armed    = armed_now;
    r.frame_ok = frame_seen;
    if (!frame_seen || thr_up <= thr_down || knee_angle >= thr_up) begin
      r.depth = '0;
    end else if (knee_angle <= thr_down) begin
      r.depth = DEPTH_FULL;
    end else begin
      num     = (int'(thr_up) - int'(knee_angle)) * 1024;
      span    = int'(thr_up) - int'(thr_down);
      r.depth = DEPTH_W'(num / span);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  // Sender: offers the next pending frame, with random gaps between items while idle_on is set.
  always @(negedge clk) begin : frame_driver
    frame_t f;
    if (!s_axis_tvalid || in_taken) begin
      if (send_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (frame_q.size() != 0) begin
        f = frame_q.pop_front();
        s_axis_tdata  <= {2'b00, f.right_angle, f.left_angle};
        s_axis_tuser  <= {f.right_seen, f.left_seen};
        s_axis_tvalid <= 1'b1;
        send_gap <= idle_on ? pick_gap() : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls while idle_on is set, plus one long hold-off so the input backs up.
  always @(negedge clk) begin : result_sink
    int gap;
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && results_seen >= 60) begin
      m_axis_tready  <= 1'b0;
      hold_left      <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else begin
      gap = (idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
      if (gap == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        hold_left <= gap - 1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    frame_t      f;
    rep_status_t want;
    rep_status_t got;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_DOWN_THR: thr_down = pwdata[ANGLE_W-1:0];
          REG_UP_THR:   thr_up = pwdata[ANGLE_W-1:0];
          REG_CONFIRM:  confirm_cnt = pwdata[RUN_W-1:0];
          default:      ;
        endcase
      end
      // Retire the output first: it belongs to an older item than any accepted now.
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (status_q.size() == 0) begin
          $error("result item arrived with no frame pending");
          errors++;
        end else begin
          want         = status_q.pop_front();
          got.angle    = m_axis_tdata[10:0];
          got.count    = m_axis_tdata[26:11];
          got.phase    = m_axis_tdata[27];
          got.armed    = m_axis_tdata[28];
          got.depth    = m_axis_tdata[39:29];
          got.frame_ok = m_axis_tuser[0];
          check_field("selected_angle", want.angle, got.angle);
          check_field("rep_count", want.count, got.count);
          check_field("phase", want.phase, got.phase);
          check_field("armed_flag", want.armed, got.armed);
          check_field("frame_valid", want.frame_ok, got.frame_ok);
          check_field("depth_progress", want.depth, got.depth);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        f.left_angle  = s_axis_tdata[10:0];
        f.right_angle = s_axis_tdata[21:11];
        f.left_seen   = s_axis_tuser[0];
        f.right_seen  = s_axis_tuser[1];
        track_frame(f, want);
        status_q.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Upper bits carry junk; only the register width should be taken.
  task automatic set_config(input logic [ANGLE_W-1:0] dn, input logic [ANGLE_W-1:0] up,
                            input logic [RUN_W-1:0] conf);
    logic [31:0] junk;
    junk = $urandom;
    apb_write(REG_DOWN_THR, {junk[31:11], dn});
    junk = $urandom;
    apb_write(REG_UP_THR, {junk[31:11], up});
    junk = $urandom;
    apb_write(REG_CONFIRM, {junk[31:8], conf});
    plan_down = dn;
    plan_up   = up;
    plan_need = (conf == '0) ? 1 : conf;
  endtask

  task automatic push_frame(input int la, input bit ls, input int ra, input bit rs);
    frame_t f;
    f.left_angle  = ANGLE_W'(la);
    f.left_seen   = ls;
    f.right_angle = ANGLE_W'(ra);
    f.right_seen  = rs;
    frame_q.push_back(f);
  endtask

  // One frame whose selected angle is a; the unused side carries an equal or larger, or junk value.
  task automatic push_angle(input int a);
    int other;
    other = $urandom_range(a, 2047);
    case ($urandom_range(0, 3))
      0:       push_frame(a, 1'b1, other, 1'b1);
      1:       push_frame(other, 1'b1, a, 1'b1);
      2:       push_frame(a, 1'b1, $urandom_range(0, 2047), 1'b0);
      default: push_frame($urandom_range(0, 2047), 1'b0, a, 1'b1);
    endcase
  endtask

  task automatic push_seg(input int n, input bit high, input int noise_pct);
    int a;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        push_frame($urandom_range(0, 2047), $urandom_range(0, 1),
                   $urandom_range(0, 2047), $urandom_range(0, 1));
      end else begin
        if (high)
          a = (plan_up >= 2047) ? 2047 : $urandom_range(int'(plan_up) + 1, 2047);
        else
          a = (plan_down == 0) ? 0 : $urandom_range(0, int'(plan_down) - 1);
        push_angle(a);
      end
    end
  endtask

  task automatic gen_reps(input int reps, input int noise_pct);
    int len;
    for (int r = 0; r < reps; r++) begin
      for (int side = 0; side < 2; side++) begin
        len = plan_need - 1 + $urandom_range(0, 2);
        if (len < 1) len = 1;
        push_seg(len, side == 1, noise_pct);
      end
    end
  endtask

  task automatic wait_idle();
    while (frame_q.size() != 0 || s_axis_tvalid || status_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    plan_down = DOWN_THR_RESET;
    plan_up   = UP_THR_RESET;
    plan_need = CONFIRM_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames at the reset settings (down 900, up 1600, confirm 3).
    push_frame(0, 1'b0, 0, 1'b0);         // no side seen
    push_frame(2047, 1'b1, 0, 1'b0);      // left only, top of the field
    push_frame(0, 1'b0, 1800, 1'b1);      // right only, smaller left ignored
    push_frame(1700, 1'b1, 2047, 1'b1);   // third standing frame arms
    push_frame(1600, 1'b1, 1601, 1'b1);   // exactly on the up threshold
    push_frame(900, 1'b1, 900, 1'b1);     // exactly on the down threshold
    push_frame(1900, 1'b1, 1250, 1'b1);   // halfway: depth 512
    push_frame(899, 1'b1, 2047, 1'b1);
    push_frame(0, 1'b0, 2047, 1'b0);      // dropout clears the down run
    push_frame(0, 1'b1, 0, 1'b1);
    push_frame(2047, 1'b0, 0, 1'b1);
    push_frame(5, 1'b1, 1024, 1'b0);      // third low frame enters the down phase
    push_frame(1601, 1'b1, 1601, 1'b1);
    push_frame(1000, 1'b1, 1700, 1'b1);   // mid-range frame breaks the up run
    push_frame(1601, 1'b1, 1700, 1'b1);
    push_frame(2047, 1'b1, 2047, 1'b1);
    push_frame(1800, 1'b0, 1800, 1'b1);   // one repetition
    push_frame(11'h555, 1'b1, 11'h2AA, 1'b1);
    push_frame(11'h2AA, 1'b0, 11'h555, 1'b1);
    wait_idle();

    idle_on = 1'b1;
    set_config(11'd900, 11'd1600, 8'd2);
    gen_reps(14, 10);
    wait_idle();

    idle_on = 1'b0;
    set_config(11'd0, 11'd1800, 8'd1);
    gen_reps(12, 15);
    wait_idle();

    // Inverted thresholds, and a confirm count of zero that acts as one.
    idle_on = 1'b1;
    set_config(11'd1500, 11'd400, 8'd0);
    gen_reps(12, 15);
    wait_idle();

    set_config(11'd1800, 11'd0, 8'd1);
    apb_write(REG_SPARE, $urandom);
    gen_reps(8, 20);
    wait_idle();

    // Leave the down phase, then run the longest confirmation.
    set_config(11'd600, 11'd1700, 8'd1);
    push_seg(1, 1'b1, 0);
    wait_idle();
    idle_on = 1'b0;
    set_config(11'd600, 11'd1700, 8'd255);
    push_seg(256, 1'b0, 0);
    push_seg(40, 1'b1, 0);
    wait_idle();

    // The up run left over from above already passes the new confirm count.
    idle_on = 1'b1;
    set_config(11'd700, 11'd1500, 8'd4);
    push_seg(1, 1'b1, 0);
    gen_reps(15, 20);
    wait_idle();

    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/karc_pkg.sv
sv/karc_div.sv
sv/knee_angle_repetition_counter_unit.sv
tb/sv/knee_angle_repetition_counter_unit_test.sv
